@@ rtl/mesh_volume_centroid_accumulator_top_macros.svh @@
// Assertion macros for the mesh volume and centroid accumulator.
`ifndef MESH_VOLUME_CENTROID_ACCUMULATOR_TOP_MACROS_SVH
`define MESH_VOLUME_CENTROID_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MVCA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mvca: property violated");

// Next-cycle implication, disabled in reset.
`define MVCA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mvca: property violated");

`endif

@@ rtl/mvca_pkg.sv @@
// Types and constants shared by the mesh volume and centroid accumulator.
package mvca_pkg;

  localparam int CW     = 12;  // coordinate field width
  localparam int DW     = 13;  // vertex minus reference
  localparam int SW     = 14;  // four-vertex sum
  localparam int PW     = 26;  // cross product term
  localparam int NW     = 27;  // cross product component
  localparam int QW     = 40;  // normal times edge term
  localparam int DTW    = 42;  // six-volume of one tetrahedron
  localparam int SPLIT  = 21;  // low part width of the moment multiply
  localparam int HPW    = SW + DTW - SPLIT;
  localparam int LPW    = SW + SPLIT + 1;
  localparam int MW     = 64;  // moment accumulator
  localparam int VW     = 48;  // volume accumulator
  localparam int IN_W   = 112;
  localparam int OUT_W  = 88;
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_REF_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REF_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REF_Z = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ZERO = 1'b1;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_ITER,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic [DW-1:0] ux;
    logic [DW-1:0] uy;
    logic [DW-1:0] uz;
    logic [DW-1:0] vx;
    logic [DW-1:0] vy;
    logic [DW-1:0] vz;
    logic [DW-1:0] wx;
    logic [DW-1:0] wy;
    logic [DW-1:0] wz;
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
    logic [SW-1:0] sz;
    logic          last;
  } tri_item_t;

  typedef struct packed {
    logic                 start;
    logic [VW-1:0]        vol;
    logic [2:0][MW-1:0]   mom;
  } div_req_t;

  typedef struct packed {
    logic [VW-1:0]        six_volume;
    logic [2:0][CW-1:0]   cent;
    logic                 status;
  } div_res_t;

endpackage

@@ rtl/mesh_volume_centroid_accumulator_top.sv @@
// Mesh volume and centroid accumulator: triangles in, six-volume and centroid out.
// Throughput: one triangle per cycle while the queue has room; a closing triangle waits
// in the queue while the previous closing triangle is in the pipeline, in the divider
// or waiting on the output. A closing beat passes the front register, the queue and the
// multiply pipeline to the one-bit-per-cycle divider, which then forms the centroid.
// Reset (async, active low) clears valids, accumulators and the reference point.
module mesh_volume_centroid_accumulator_top import mvca_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CW-1:0]        cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 4 zero bits
  input  logic [IN_W-1:0]      s_axis_tdata_i,
  input  logic                 s_axis_tlast_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // six_volume, cent_x, cent_y, cent_z, 4 zero bits
  output logic [OUT_W-1:0]     m_axis_tdata_o,
  // status
  output logic                 m_axis_tuser_o
);

  logic      f_valid, f_ready, q_valid, q_ready, div_idle;
  tri_item_t f_item, q_item;
  div_req_t  req;
  div_res_t  res;

  mvca_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  mvca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  (f_item),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_item)
  );

  mvca_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .div_idle_i   (div_idle),
    .req_o        (req)
  );

  mvca_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .idle_o      (div_idle),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {4'b0000, res.cent[2], res.cent[1], res.cent[0], res.six_volume};
  assign m_axis_tuser_o = res.status;

endmodule

@@ rtl/mvca_front.sv @@
// Front end: takes triangle beats, holds the reference point, forms edge vectors and sums.
module mvca_front import mvca_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_W-1:0]      in_data_i,
  input  logic                 in_last_i,
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output tri_item_t            item_o
);

  function automatic logic [CW-1:0] sx(input logic [CW-1:0] v);
    sx = CW'($signed(v[COORD_BITS-1:0]));
  endfunction

  logic [CW-1:0] ref_q [3];
  logic [CW-1:0] crd [9];
  logic          vld_q;
  tri_item_t     item_q, item_d;
  logic          acc;

  for (genvar g = 0; g < 9; g++) begin : g_crd
    assign crd[g] = sx(in_data_i[g*CW +: CW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q[0] <= '0;
      ref_q[1] <= '0;
      ref_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REF_X: ref_q[0] <= sx(cfg_data_i);
        REG_REF_Y: ref_q[1] <= sx(cfg_data_i);
        REG_REF_Z: ref_q[2] <= sx(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    item_d.ux = DW'($signed(crd[0])) - DW'($signed(ref_q[0]));
    item_d.uy = DW'($signed(crd[1])) - DW'($signed(ref_q[1]));
    item_d.uz = DW'($signed(crd[2])) - DW'($signed(ref_q[2]));
    item_d.vx = DW'($signed(crd[3])) - DW'($signed(ref_q[0]));
    item_d.vy = DW'($signed(crd[4])) - DW'($signed(ref_q[1]));
    item_d.vz = DW'($signed(crd[5])) - DW'($signed(ref_q[2]));
    item_d.wx = DW'($signed(crd[6])) - DW'($signed(ref_q[0]));
    item_d.wy = DW'($signed(crd[7])) - DW'($signed(ref_q[1]));
    item_d.wz = DW'($signed(crd[8])) - DW'($signed(ref_q[2]));
    item_d.sx = SW'($signed(crd[0])) + SW'($signed(crd[3])) + SW'($signed(crd[6]))
              + SW'($signed(ref_q[0]));
    item_d.sy = SW'($signed(crd[1])) + SW'($signed(crd[4])) + SW'($signed(crd[7]))
              + SW'($signed(ref_q[1]));
    item_d.sz = SW'($signed(crd[2])) + SW'($signed(crd[5])) + SW'($signed(crd[8]))
              + SW'($signed(ref_q[2]));
    item_d.last = in_last_i;
  end

  assign in_ready_o   = !vld_q || item_ready_i;
  assign acc          = in_valid_i && in_ready_o;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q <= item_d;
    end
  end

endmodule

@@ rtl/mvca_queue.sv @@
// Small FIFO between the front end and the accumulate pipeline.
module mvca_queue import mvca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  tri_item_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output tri_item_t data_o
);

  tri_item_t      mem_q [QDEPTH];
  logic [QPW-1:0] wr_q, rd_q;
  logic [QPW:0]   cnt_q;
  logic           push, pop;

  assign ready_o = cnt_q != (QPW+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/mvca_div.sv @@
// Centroid divider: restoring division of each moment by four times the volume, one bit a cycle.
module mvca_div import mvca_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output logic     idle_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output div_res_t res_o
);

  localparam int CNTW = $clog2(COORD_BITS + 1);
  localparam int QBW  = COORD_BITS + 1;
  localparam logic [QBW-1:0] HALF = QBW'(1) << (COORD_BITS - 1);
  localparam logic [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  div_state_e         state_q, state_d;
  logic [1:0]         axis_q, axis_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [MW-1:0]      rem_q, rem_d;
  logic [MW-1:0]      dsh_q, dsh_d;
  logic [MW-1:0]      dabs_q, dabs_d;
  logic [QBW-1:0]     quo_q, quo_d;
  logic               neg_q, neg_d;
  logic               vsign_q, vsign_d;
  logic [VW-1:0]      six_q, six_d;
  logic [2:0][MW-1:0] mom_q, mom_d;
  logic [2:0][CW-1:0] cent_q, cent_d;
  logic               status_q, status_d;

  logic [VW-1:0]         vol_abs;
  logic [MW-1:0]         num;
  logic                  ge;
  logic [QBW-1:0]        quo_nx;
  logic [COORD_BITS-1:0] qres;

  assign vol_abs = req_i.vol[VW-1] ? (~req_i.vol + 1'b1) : req_i.vol;
  assign num     = mom_q[axis_q];
  assign ge      = rem_q >= dsh_q;
  assign quo_nx  = {quo_q[QBW-2:0], ge};

  always_comb begin
    if (neg_q) begin
      qres = (quo_nx > HALF) ? SAT_LO : (~quo_nx[COORD_BITS-1:0] + 1'b1);
    end else begin
      qres = (quo_nx >= HALF) ? SAT_HI : quo_nx[COORD_BITS-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    dabs_d   = dabs_q;
    quo_d    = quo_q;
    neg_d    = neg_q;
    vsign_d  = vsign_q;
    six_d    = six_q;
    mom_d    = mom_q;
    cent_d   = cent_q;
    status_d = status_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          mom_d   = req_i.mom;
          six_d   = req_i.vol;
          vsign_d = req_i.vol[VW-1];
          dabs_d  = MW'(vol_abs) << 2;
          axis_d  = '0;
          if (req_i.vol == '0) begin
            cent_d   = '0;
            status_d = STATUS_ZERO;
            state_d  = DIV_DONE;
          end else begin
            status_d = STATUS_OK;
            state_d  = DIV_LOAD;
          end
        end
      end
      DIV_LOAD: begin
        rem_d   = num[MW-1] ? (~num + 1'b1) : num;
        neg_d   = num[MW-1] ^ vsign_q;
        dsh_d   = dabs_q << COORD_BITS;
        cnt_d   = CNTW'(COORD_BITS);
        quo_d   = '0;
        state_d = DIV_ITER;
      end
      DIV_ITER: begin
        quo_d = quo_nx;
        rem_d = ge ? (rem_q - dsh_q) : rem_q;
        dsh_d = dsh_q >> 1;
        if (cnt_q == '0) begin
          cent_d[axis_q] = CW'($signed(qres));
          if (axis_q == 2'd2) begin
            state_d = DIV_DONE;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = DIV_LOAD;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      DIV_DONE: begin
        if (res_ready_i) state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q   <= axis_d;
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    dsh_q    <= dsh_d;
    dabs_q   <= dabs_d;
    quo_q    <= quo_d;
    neg_q    <= neg_d;
    vsign_q  <= vsign_d;
    six_q    <= six_d;
    mom_q    <= mom_d;
    cent_q   <= cent_d;
    status_q <= status_d;
  end

  assign idle_o           = state_q == DIV_IDLE;
  assign res_valid_o      = state_q == DIV_DONE;
  assign res_o.six_volume = six_q;
  assign res_o.cent       = cent_q;
  assign res_o.status     = status_q;

endmodule

@@ rtl/mvca_back.sv @@
// Back end: six-stage multiply pipeline and the volume and moment accumulators.
module mvca_back import mvca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  tri_item_t item_i,
  input  logic      div_idle_i,
  output div_req_t  req_o
);

  logic               pop;
  logic               last_pend_q;
  logic [6:1]         v_q;

  logic [PW-1:0]      p1_q [6];
  logic [2:0][DW-1:0] w1_q, w2_q;
  logic [2:0][SW-1:0] s1_q, s2_q, s3_q, s4_q;
  logic [2:0][NW-1:0] n2_q;
  logic [2:0][QW-1:0] q3_q;
  logic [DTW-1:0]     d4_q, d5_q, d6_q;
  logic [2:0][HPW-1:0] ph5_q;
  logic [2:0][LPW-1:0] pl5_q;
  logic [2:0][MW-1:0] m6_q;
  logic [6:1]         l_q;

  logic [DTW-SPLIT-1:0] dh;
  logic [SPLIT-1:0]     dl;
  logic [VW-1:0]        vol_q, vol_nx;
  logic [2:0][MW-1:0]   mom_q, mom_nx;
  logic                 fin;

  // a closing triangle waits until the divider is free and no other one is in flight
  assign item_ready_o = !item_i.last || (!last_pend_q && div_idle_i);
  assign pop          = item_valid_i && item_ready_o;

  assign dh = d4_q[DTW-1:SPLIT];
  assign dl = d4_q[SPLIT-1:0];

  always_ff @(posedge clk_i) begin
    p1_q[0] <= PW'($signed(item_i.uy)) * PW'($signed(item_i.vz));
    p1_q[1] <= PW'($signed(item_i.uz)) * PW'($signed(item_i.vy));
    p1_q[2] <= PW'($signed(item_i.uz)) * PW'($signed(item_i.vx));
    p1_q[3] <= PW'($signed(item_i.ux)) * PW'($signed(item_i.vz));
    p1_q[4] <= PW'($signed(item_i.ux)) * PW'($signed(item_i.vy));
    p1_q[5] <= PW'($signed(item_i.uy)) * PW'($signed(item_i.vx));
    w1_q    <= {item_i.wz, item_i.wy, item_i.wx};
    s1_q    <= {item_i.sz, item_i.sy, item_i.sx};
    l_q[1]  <= item_i.last;

    for (int k = 0; k < 3; k++) begin
      n2_q[k]  <= NW'($signed(p1_q[2*k])) - NW'($signed(p1_q[2*k+1]));
      q3_q[k]  <= QW'($signed(n2_q[k])) * QW'($signed(w2_q[k]));
      ph5_q[k] <= HPW'($signed(s4_q[k])) * HPW'($signed(dh));
      pl5_q[k] <= LPW'($signed(s4_q[k])) * LPW'($signed({1'b0, dl}));
      m6_q[k]  <= (MW'($signed(ph5_q[k])) <<< SPLIT) + MW'($signed(pl5_q[k]));
    end
    w2_q   <= w1_q;
    s2_q   <= s1_q;
    s3_q   <= s2_q;
    s4_q   <= s3_q;
    d4_q   <= DTW'($signed(q3_q[0])) + DTW'($signed(q3_q[1])) + DTW'($signed(q3_q[2]));
    d5_q   <= d4_q;
    d6_q   <= d5_q;
    l_q[6:2] <= l_q[5:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:1], pop};
    end
  end

  assign fin    = v_q[6] && l_q[6];
  assign vol_nx = vol_q + VW'($signed(d6_q));
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mom_nx[k] = mom_q[k] + m6_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q       <= '0;
      mom_q       <= '0;
      last_pend_q <= 1'b0;
    end else begin
      if (v_q[6]) begin
        vol_q <= fin ? '0 : vol_nx;
        mom_q <= fin ? '0 : mom_nx;
      end
      if (pop && item_i.last) begin
        last_pend_q <= 1'b1;
      end else if (fin) begin
        last_pend_q <= 1'b0;
      end
    end
  end

  assign req_o.start = fin;
  assign req_o.vol   = vol_nx;
  assign req_o.mom   = mom_nx;

endmodule

@@ rtl/mvca_checker.sv @@
// Port-level checks for the mesh volume and centroid accumulator, bound to the top level.
`include "mesh_volume_centroid_accumulator_top_macros.svh"

module mvca_checker import mvca_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic             m_axis_tuser_o
);

  logic           out_wait;
  logic           out_zero;
  logic           out_ok;
  logic [OUT_W:0] out_beat;

  assign out_wait = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_zero = m_axis_tvalid_o && m_axis_tuser_o == STATUS_ZERO;
  assign out_ok   = m_axis_tvalid_o && m_axis_tuser_o == STATUS_OK;
  assign out_beat = {m_axis_tuser_o, m_axis_tdata_o};

  `MVCA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid_o)
  `MVCA_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_wait, $stable(out_beat))
  `MVCA_ASSERT_IMP(a_zero_clean, clk_i, rst_ni, out_zero, m_axis_tdata_o == '0)
  `MVCA_ASSERT_IMP(a_ok_nonzero, clk_i, rst_ni, out_ok, m_axis_tdata_o[VW-1:0] != '0)

endmodule

bind mesh_volume_centroid_accumulator_top mvca_checker u_mvca_checker (.*);

@@ tb/mesh_volume_centroid_checker.sv @@
// Checker: predicts six-volume and centroid per closed mesh, compares every output beat.
module mesh_volume_centroid_checker import mvca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CW-1:0]        cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 4 zero bits
  input  logic [IN_W-1:0]      s_tdata_i,
  input  logic                 s_tlast_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  // six_volume, cent_x, cent_y, cent_z, 4 zero bits
  input  logic [OUT_W-1:0]     m_tdata_i,
  // status
  input  logic                 m_tuser_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [VW-1:0] six_volume;
    logic [CW-1:0] cent_x;
    logic [CW-1:0] cent_y;
    logic [CW-1:0] cent_z;
    logic          status;
  } mesh_result_t;

  mesh_result_t  mesh_results_q[$];
  longint        apex[3];
  logic [VW-1:0] volume_acc;
  longint        moment_acc[3];

  function automatic logic [CW-1:0] centroid_of(longint moment, longint total);
    longint hi;
    longint lo;
    longint q;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    q  = moment / (total * 4);
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[CW-1:0];
  endfunction

  function automatic void add_triangle(logic [IN_W-1:0] beat, logic last);
    longint       p[9];
    longint       u[3];
    longint       v[3];
    longint       w[3];
    longint       n[3];
    longint       s[3];
    longint       d;
    longint       total;
    mesh_result_t res;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(beat[i*CW +: CW]));
    for (int k = 0; k < 3; k++) begin
      u[k] = p[k] - apex[k];
      v[k] = p[3+k] - apex[k];
      w[k] = p[6+k] - apex[k];
      s[k] = p[k] + p[3+k] + p[6+k] + apex[k];
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    d = n[0] * w[0] + n[1] * w[1] + n[2] * w[2];
    volume_acc = volume_acc + d[VW-1:0];
    for (int k = 0; k < 3; k++) moment_acc[k] = moment_acc[k] + s[k] * d;
    if (!last) return;
    total = longint'($signed(volume_acc));
    res.six_volume = volume_acc;
    if (total == 0) begin
      res.cent_x = '0;
      res.cent_y = '0;
      res.cent_z = '0;
      res.status = STATUS_ZERO;
    end else begin
      res.cent_x = centroid_of(moment_acc[0], total);
      res.cent_y = centroid_of(moment_acc[1], total);
      res.cent_z = centroid_of(moment_acc[2], total);
      res.status = STATUS_OK;
    end
    mesh_results_q = {mesh_results_q, res};
    volume_acc = '0;
    moment_acc = '{0, 0, 0};
  endfunction

  function automatic void check_beat(logic [OUT_W-1:0] beat, logic user);
    mesh_result_t got;
    mesh_result_t want;
    got.six_volume = beat[0 +: VW];
    got.cent_x     = beat[VW +: CW];
    got.cent_y     = beat[VW+CW +: CW];
    got.cent_z     = beat[VW+2*CW +: CW];
    got.status     = user;
    if (mesh_results_q.size() == 0) begin
      errors_o++;
      if (errors_o <= 10)
        $display("unexpected result beat: vol=%0d cent=(%0d,%0d,%0d) status=%0b",
                 $signed(got.six_volume), $signed(got.cent_x), $signed(got.cent_y),
                 $signed(got.cent_z), got.status);
      return;
    end
    want = mesh_results_q.pop_front();
    if (got.six_volume != want.six_volume || got.cent_x != want.cent_x ||
        got.cent_y != want.cent_y || got.cent_z != want.cent_z ||
        got.status != want.status) begin
      errors_o++;
      if (errors_o <= 10)
        $display("result mismatch: exp vol=%0d cent=(%0d,%0d,%0d) status=%0b, got vol=%0d cent=(%0d,%0d,%0d) status=%0b",
                 $signed(want.six_volume), $signed(want.cent_x), $signed(want.cent_y),
                 $signed(want.cent_z), want.status,
                 $signed(got.six_volume), $signed(got.cent_x), $signed(got.cent_y),
                 $signed(got.cent_z), got.status);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apex       = '{0, 0, 0};
      volume_acc = '0;
      moment_acc = '{0, 0, 0};
      mesh_results_q.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_beat(m_tdata_i, m_tuser_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REF_X: apex[0] = longint'($signed(cfg_data_i));
          REG_REF_Y: apex[1] = longint'($signed(cfg_data_i));
          REG_REF_Z: apex[2] = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) add_triangle(s_tdata_i, s_tlast_i);
      pending_o = mesh_results_q.size();
    end
  end

endmodule

@@ tb/mesh_volume_centroid_accumulator_top_tb.sv @@
// Testbench top: drives triangle meshes and apex writes, gives the verdict.
module mesh_volume_centroid_accumulator_top_tb;
  import mvca_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;  // not mapped, writes ignored
  localparam int MAX_GAP        = 16;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 48;
  localparam int SQUEEZE_ITEMS  = 24;
  localparam int LONG_TRIANGLES = 200;

  // box faces, corner index = x | y << 1 | z << 2, outward winding, lowest first
  localparam logic [71:0] BOX_FACES = {
    3'd5, 3'd7, 3'd3, 3'd1,  3'd2, 3'd6, 3'd4, 3'd0,  3'd3, 3'd7, 3'd6, 3'd2,
    3'd4, 3'd5, 3'd1, 3'd0,  3'd6, 3'd7, 3'd5, 3'd4,  3'd1, 3'd3, 3'd2, 3'd0
  };
  localparam logic [23:0] TET_FACES = {
    2'd2, 2'd3, 2'd1,  2'd3, 2'd2, 2'd0,  2'd1, 2'd3, 2'd0,  2'd2, 2'd1, 2'd0
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [CW-1:0]        cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tuser;
  int                   error_count;
  int                   pending_count;

  bit fast_send;
  bit fast_recv;
  bit squeeze_req;
  int triangles_sent;
  int tet_x[4];
  int tet_y[4];
  int tet_z[4];

  mesh_volume_centroid_accumulator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  mesh_volume_centroid_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .errors_o   (error_count),
    .pending_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int rnd_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int box_pt(int idx, int axis, int lo, int hi);
    return ((idx >> axis) & 1) ? hi : lo;
  endfunction

  task automatic send_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz, input logic last);
    logic [IN_W-1:0] beat;
    int              gap;
    beat = '0;
    beat[9*CW-1:0] = {cz[CW-1:0], cy[CW-1:0], cx[CW-1:0], bz[CW-1:0], by[CW-1:0],
                      bx[CW-1:0], az[CW-1:0], ay[CW-1:0], ax[CW-1:0]};
    gap = fast_send ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    triangles_sent++;
  endtask

  task automatic write_apex(input int x, y, z);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_REF_X;
    cfg_data <= x[CW-1:0];
    @(posedge clk_i);
    cfg_idx  <= REG_REF_Y;
    cfg_data <= y[CW-1:0];
    @(posedge clk_i);
    cfg_idx  <= REG_REF_Z;
    cfg_data <= z[CW-1:0];
    @(posedge clk_i);
    cfg_idx  <= REG_SPARE;
    cfg_data <= CW'($urandom_range(0, 4095));
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid, wait for every result, then let the pipeline drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_box(input int x0, x1, y0, y1, z0, z1, input bit inward,
                          input int ntri, input bit close);
    int q[4];
    int i0;
    int i1;
    int i2;
    int n;
    n = 0;
    for (int f = 0; f < 6; f++) begin
      for (int k = 0; k < 4; k++) q[k] = BOX_FACES[(f*4+k)*3 +: 3];
      for (int t = 0; t < 2; t++) begin
        if (n < ntri) begin
          i0 = q[0];
          i1 = inward ? q[t+2] : q[t+1];
          i2 = inward ? q[t+1] : q[t+2];
          send_tri(box_pt(i0, 0, x0, x1), box_pt(i0, 1, y0, y1), box_pt(i0, 2, z0, z1),
                   box_pt(i1, 0, x0, x1), box_pt(i1, 1, y0, y1), box_pt(i1, 2, z0, z1),
                   box_pt(i2, 0, x0, x1), box_pt(i2, 1, y0, y1), box_pt(i2, 2, z0, z1),
                   close && (n == ntri - 1));
        end
        n++;
      end
    end
  endtask

  task automatic send_random_box(input bit inward, input int ntri);
    int a[6];
    for (int k = 0; k < 6; k++) a[k] = rnd_coord();
    send_box(a[0] < a[1] ? a[0] : a[1], a[0] < a[1] ? a[1] : a[0],
             a[2] < a[3] ? a[2] : a[3], a[2] < a[3] ? a[3] : a[2],
             a[4] < a[5] ? a[4] : a[5], a[4] < a[5] ? a[5] : a[4],
             inward, ntri, 1'b1);
  endtask

  task automatic pick_tetra();
    for (int k = 0; k < 4; k++) begin
      tet_x[k] = rnd_coord();
      tet_y[k] = rnd_coord();
      tet_z[k] = rnd_coord();
    end
  endtask

  task automatic send_tetra(input bit inward, input bit close);
    int i0;
    int i1;
    int i2;
    for (int f = 0; f < 4; f++) begin
      i0 = TET_FACES[(f*3)*2 +: 2];
      i1 = inward ? TET_FACES[(f*3+2)*2 +: 2] : TET_FACES[(f*3+1)*2 +: 2];
      i2 = inward ? TET_FACES[(f*3+1)*2 +: 2] : TET_FACES[(f*3+2)*2 +: 2];
      send_tri(tet_x[i0], tet_y[i0], tet_z[i0], tet_x[i1], tet_y[i1], tet_z[i1],
               tet_x[i2], tet_y[i2], tet_z[i2], close && (f == 3));
    end
  endtask

  task automatic send_soup(input int ntri);
    for (int k = 0; k < ntri; k++)
      send_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
               rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), k == ntri - 1);
  endtask

  task automatic send_frame();
    bit inw;
    inw       = $urandom_range(0, 1);
    fast_send = ($urandom_range(0, 3) == 0);
    fast_recv = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_random_box(inw, 12);
      4, 5: begin
        pick_tetra();
        send_tetra(inw, 1'b1);
      end
      6, 7: send_soup($urandom_range(1, 6));
      8: begin
        // same solid both ways round: total cancels
        pick_tetra();
        send_tetra(inw, 1'b0);
        send_tetra(!inw, 1'b1);
      end
      default: send_random_box(inw, $urandom_range(1, 11));
    endcase
  endtask

  initial begin
    int target;
    rst_ni   <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_REF_X;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_apex(0, 0, 0);
    send_tri(64, 0, 0, 0, 64, 0, 0, 0, 64, 1'b1);
    send_tri(2047, 2047, -2048, -2048, 2047, 2047, 2047, -2048, 2047, 1'b1);
    send_tri(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, 1'b1);
    send_tri(2047, 2047, 2047, -2048, 2047, -2048, 2047, -2048, 0, 1'b1);
    // nearly cancelling pairs: centroid saturates high, then low
    send_tri(2047, 0, 0, 0, 2047, 0, 0, 0, 2047, 1'b0);
    send_tri(-2047, 0, 0, 0, 2047, 0, 0, 0, 2046, 1'b1);
    send_tri(-2047, 0, 0, 0, 2047, 0, 0, 0, 2047, 1'b0);
    send_tri(2047, 0, 0, 0, 2047, 0, 0, 0, 2046, 1'b1);
    send_box(-2048, 2047, -2048, 2047, -2048, 2047, 1'b0, 12, 1'b1);
    settle();
    write_apex(-2048, -2048, -2048);
    send_tri(2047, 2047, -2048, -2048, 2047, 2047, 2047, -2048, 2047, 1'b1);
    settle();
    write_apex(2047, 2047, 2047);
    send_tri(-2048, -2048, 2047, 2047, -2048, -2048, -2048, 2047, -2048, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: write_apex(0, 0, 0);
        1: write_apex(-2048, -2048, -2048);
        2: write_apex(2047, 2047, 2047);
        default: write_apex(rnd_coord(), rnd_coord(), rnd_coord());
      endcase
      target = triangles_sent + PHASE_ITEMS;
      while (triangles_sent < target) send_frame();
    end

    // output held off while single-triangle meshes keep coming
    settle();
    fast_send   = 1'b1;
    squeeze_req = 1'b1;
    for (int k = 0; k < SQUEEZE_ITEMS; k++) send_soup(1);
    fast_send   = 1'b0;

    // one long mesh of largest tetrahedra: large sums in every accumulator
    settle();
    write_apex(-2048, -2048, -2048);
    for (int k = 0; k < LONG_TRIANGLES; k++)
      send_tri(2047, 2047, -2048, -2048, 2047, 2047, 2047, -2048, 2047,
               k == LONG_TRIANGLES - 1);

    settle();
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    int stall;
    m_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = fast_recv ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid && !squeeze_req);
    end
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mvca_pkg.sv
rtl/mvca_front.sv
rtl/mvca_queue.sv
rtl/mvca_div.sv
rtl/mvca_back.sv
rtl/mesh_volume_centroid_accumulator_top.sv
rtl/mvca_checker.sv
tb/mesh_volume_centroid_checker.sv
tb/mesh_volume_centroid_accumulator_top_tb.sv
